@@ src/hpf_nonpreemptive_scheduler_assert.svh @@
// Assertion macros shared by the scheduler modules.
// Needs nothing else; each module that checks itself includes this header.
`ifndef HPF_NONPREEMPTIVE_SCHEDULER_ASSERT_SVH
`define HPF_NONPREEMPTIVE_SCHEDULER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HPF_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hpf scheduler check failed");

// The consequent must hold in the cycle after the antecedent.
`define HPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hpf scheduler check failed");

`endif

@@ src/hpf_pkg.sv @@
// Shared types and constants of the priority scheduler.
// No dependencies; every module of the block imports this package.
package hpf_pkg;

  // Opcode values of an input item.
  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // One scheduling quantum in tenths.
  localparam logic [6:0] QUANTUM = 7'd10;

  // Input item.
  typedef struct packed {
    logic        opcode;
    logic [7:0]  job_id;
    logic [2:0]  job_priority;
    logic [6:0]  run_time;
    logic [15:0] arrival_time;
  } item_t;

  // Result item.
  typedef struct packed {
    logic        dropped;
    logic        busy_res;
    logic [7:0]  running_id;
    logic        started;
    logic        completed;
    logic [12:0] finish_tick;
    logic [15:0] turnaround;
    logic [15:0] waiting;
  } result_t;

  // One queued job.
  typedef struct packed {
    logic [7:0]  id;
    logic [6:0]  run;
    logic [15:0] arr;
  } entry_t;

  // Decision record handed from the queue control to the result stage.
  typedef struct packed {
    logic        dropped;
    logic        busy;
    logic        started;
    logic        completed;
    entry_t      job;
    logic [12:0] fin;
    logic [16:0] fin_t;
  } stage_t;

endpackage

@@ src/hpf_store.sv @@
// Ready-queue storage: one job entry per slot of every priority level.
// Depends on hpf_pkg for the entry type.
module hpf_store
  import hpf_pkg::*;
#(
  parameter int NUM_LEVELS  = 4,
  parameter int QUEUE_DEPTH = 256,
  localparam int LW = $clog2(NUM_LEVELS),
  localparam int QW = $clog2(QUEUE_DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [LW-1:0] wr_level,
  input  logic [QW-1:0] wr_index,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [LW-1:0] rd_level,
  input  logic [QW-1:0] rd_index,
  output entry_t        rd_data
);

  entry_t mem [NUM_LEVELS][QUEUE_DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_level][wr_index] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_level][rd_index];
    end
  end

endmodule

@@ src/hpf_result.sv @@
// Result stage: holds one decision record, merges the fetched job and
// computes the timing figures into the output register. Depends on hpf_pkg.
`include "hpf_nonpreemptive_scheduler_assert.svh"
module hpf_result
  import hpf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  stage_t  stage,
  input  entry_t  fetched,
  output logic    take_ok,
  output logic    res_valid,
  input  logic    res_stall,
  output result_t res
);

  logic        s1_valid;
  stage_t      s1;
  logic        move;
  entry_t      src;
  logic        done;
  logic [16:0] ta_full;
  logic [15:0] ta;
  logic [15:0] wt;
  result_t     res_next;

  // The record moves on when the output register is empty or being taken.
  assign move    = s1_valid && (!res_valid || !res_stall);
  assign take_ok = !s1_valid || move;

  // Decision record occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1 <= stage;
    end
  end

  // A job picked on this item comes from the store read port.
  always_comb begin
    src  = s1.started ? fetched : s1.job;
    done = s1.started ? (fetched.run <= QUANTUM) : s1.completed;
  end

  // Turnaround and waiting, both saturating at zero.
  always_comb begin
    ta_full = (s1.fin_t > {1'b0, src.arr}) ? (s1.fin_t - {1'b0, src.arr}) : 17'd0;
    ta      = ta_full[15:0];
    wt      = (ta > {9'b0, src.run}) ? (ta - {9'b0, src.run}) : 16'd0;
  end

  always_comb begin
    res_next             = '0;
    res_next.dropped     = s1.dropped;
    res_next.busy_res    = s1.busy;
    res_next.started     = s1.started;
    res_next.running_id  = s1.busy ? src.id : 8'd0;
    res_next.completed   = s1.busy && done;
    if (s1.busy && done) begin
      res_next.finish_tick = s1.fin;
      res_next.turnaround  = ta;
      res_next.waiting     = wt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (move) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      res <= res_next;
    end
  end

  `HPF_ASSERT_NEXT(a_record_holds, clk, rst, s1_valid && !move && !load, s1_valid && $stable(s1))
  `HPF_ASSERT_SAME(a_done_when_busy, clk, rst, res_valid && res.completed, res.busy_res)

endmodule

@@ src/hpf_nonpreemptive_scheduler.sv @@
// Non-preemptive highest-priority-first scheduler, top level.
// Uses hpf_pkg, hpf_store and hpf_result.
// Input channel item_valid / item_stall / item carries arrive and tick items;
// the output channel res_valid / res_stall / res returns exactly one result
// per item, in order. An arrive item queues a job at its priority level or
// is flagged as dropped; a tick item runs one quantum of the current job,
// first taking the head of the highest non-empty level when the CPU is free.
// Throughput is one item per cycle while item_stall is low. After an item is
// accepted, the queue decision and store read are registered first, and the
// timing arithmetic then goes into the output register to give the result.
// A stalled receiver holds the result; one more decision record waits behind
// it, and after that item_stall rises until the output is taken.
// Synchronous reset empties all queues, idles the CPU and clears the tick
// count; the store itself is not cleared, since only written slots are read.
`include "hpf_nonpreemptive_scheduler_assert.svh"
module hpf_nonpreemptive_scheduler
  import hpf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 256,
  parameter int NUM_LEVELS  = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    res_valid,
  input  logic    res_stall,
  output result_t res
);

  localparam int LW = $clog2(NUM_LEVELS);
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  function automatic logic [QW-1:0] next_idx(input logic [QW-1:0] idx);
    next_idx = (idx == QW'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  // Queue pointers and occupancy per level.
  logic [QW-1:0]         head  [NUM_LEVELS];
  logic [QW-1:0]         tail  [NUM_LEVELS];
  logic [CW-1:0]         count [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] nonempty;
  logic [NUM_LEVELS-1:0] full;

  // CPU state. When pick_pending is set the running job still sits in the
  // store read register and has already had its first quantum.
  logic        cpu_busy;
  logic        pick_pending;
  entry_t      cur;
  logic [6:0]  cur_remaining;
  logic [11:0] tick_count;

  logic          acc;
  logic          take_ok;
  logic          is_tick;
  logic          prio_ok;
  logic          drop;
  logic          push;
  logic          pop;
  logic          any_ready;
  logic          comp;
  logic [LW-1:0] lv;
  logic [LW-1:0] sel;
  entry_t        rd;
  entry_t        wr_entry;
  entry_t        eff_job;
  logic          eff_present;
  logic [6:0]    eff_rem;
  stage_t        stage;
  logic [12:0]   fin;

  assign acc        = item_valid && take_ok;
  assign item_stall = !take_ok;
  assign is_tick    = (item.opcode == OP_TICK);

  // Level flags.
  always_comb begin
    for (int l = 0; l < NUM_LEVELS; l++) begin
      nonempty[l] = (count[l] != '0);
      full[l]     = (count[l] == CW'(QUEUE_DEPTH));
    end
  end

  // Highest non-empty level, lowest index first.
  always_comb begin
    sel       = '0;
    any_ready = 1'b0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (nonempty[l]) begin
        sel       = LW'(l);
        any_ready = 1'b1;
      end
    end
  end

  // Arrival level and drop check.
  assign prio_ok = (item.job_priority != 3'd0) && (32'(item.job_priority) <= NUM_LEVELS);
  assign lv      = LW'({{LW{1'b0}}, item.job_priority - 3'd1});
  assign drop    = !prio_ok || full[lv];
  assign push    = acc && !is_tick && !drop;

  // Current job as seen by this item, resolving a pick from the last item.
  always_comb begin
    if (pick_pending) begin
      eff_job     = rd;
      eff_present = (rd.run > QUANTUM);
      eff_rem     = rd.run - QUANTUM;
    end else begin
      eff_job     = cur;
      eff_present = cpu_busy;
      eff_rem     = cur_remaining;
    end
  end

  assign pop  = acc && is_tick && !eff_present && any_ready;
  assign comp = (eff_rem <= QUANTUM);
  assign fin  = {1'b0, tick_count} + 13'd1;

  // Decision record for the result stage.
  always_comb begin
    stage       = '0;
    stage.fin   = fin;
    stage.fin_t = {4'b0, fin} * 17'(QUANTUM);
    stage.job   = eff_job;
    if (is_tick) begin
      stage.busy      = eff_present || any_ready;
      stage.started   = !eff_present && any_ready;
      stage.completed = eff_present && comp;
    end else begin
      stage.dropped = drop;
    end
  end

  // Queue pointer and occupancy update.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head[l]  <= '0;
        tail[l]  <= '0;
        count[l] <= '0;
      end
    end else begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        if (push && lv == LW'(l)) begin
          tail[l]  <= next_idx(tail[l]);
          count[l] <= count[l] + CW'(1);
        end
        if (pop && sel == LW'(l)) begin
          head[l]  <= next_idx(head[l]);
          count[l] <= count[l] - CW'(1);
        end
      end
    end
  end

  // CPU control state and tick counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      cpu_busy     <= 1'b0;
      pick_pending <= 1'b0;
      tick_count   <= '0;
    end else if (acc) begin
      pick_pending <= pop;
      if (is_tick) begin
        tick_count <= tick_count + 12'd1;
        if (pop) begin
          cpu_busy <= 1'b1;
        end else begin
          cpu_busy <= eff_present && !comp;
        end
      end else begin
        cpu_busy <= eff_present;
      end
    end
  end

  // Running job details.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur           <= '0;
      cur_remaining <= '0;
    end else if (acc) begin
      cur <= eff_job;
      if (is_tick && eff_present) begin
        cur_remaining <= eff_rem - QUANTUM;
      end else begin
        cur_remaining <= eff_rem;
      end
    end
  end

  assign wr_entry = '{id: item.job_id, run: item.run_time, arr: item.arrival_time};

  hpf_store #(
    .NUM_LEVELS  (NUM_LEVELS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk      (clk),
    .wr_en    (push),
    .wr_level (lv),
    .wr_index (tail[lv]),
    .wr_data  (wr_entry),
    .rd_en    (pop),
    .rd_level (sel),
    .rd_index (head[sel]),
    .rd_data  (rd)
  );

  hpf_result u_result (
    .clk       (clk),
    .rst       (rst),
    .load      (acc),
    .stage     (stage),
    .fetched   (rd),
    .take_ok   (take_ok),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  `HPF_ASSERT_SAME(a_pending_busy, clk, rst, pick_pending, cpu_busy)
  `HPF_ASSERT_NEXT(a_tick_count, clk, rst, !rst && acc && is_tick, tick_count == 12'($past(tick_count) + 12'd1))

endmodule

@@ sim/hpf_scheduler_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the priority scheduler: it watches both channels, predicts
// each result from the accepted items and compares it field by field.
// Depends on hpf_pkg for the item and result types and the quantum constant.
module hpf_scheduler_checker
  import hpf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 256,
  parameter int NUM_LEVELS  = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  logic    item_stall,
  input  item_t   item,
  input  logic    res_valid,
  input  logic    res_stall,
  input  result_t res,
  output int      mismatches,
  output int      pending
);

  // Scheduler state as the checker sees it.
  entry_t      ready_jobs[NUM_LEVELS][$];
  logic        cpu_busy;
  entry_t      running;
  int unsigned time_left;
  logic [11:0] tick_now;

  // Results still owed by the block, oldest first.
  result_t outcome_fifo[$];

  // Applies one item to the scheduler state and returns the result it causes.
  function automatic result_t schedule_outcome(input item_t it);
    result_t     r;
    entry_t      job;
    int          lv;
    int unsigned fin, fin_t, ta, wt;
    r = '0;
    if (it.opcode == OP_ARRIVE) begin
      // A priority outside the levels or a full level discards the job.
      if (it.job_priority == 3'd0 || it.job_priority > NUM_LEVELS) begin
        r.dropped = 1'b1;
      end else if (ready_jobs[it.job_priority - 1].size() >= QUEUE_DEPTH) begin
        r.dropped = 1'b1;
      end else begin
        job.id  = it.job_id;
        job.run = it.run_time;
        job.arr = it.arrival_time;
        ready_jobs[it.job_priority - 1].push_back(job);
      end
      return r;
    end

    // A free CPU takes the head of the highest non-empty level.
    for (lv = 0; lv < NUM_LEVELS && !cpu_busy; lv++) begin
      if (ready_jobs[lv].size() != 0) begin
        running   = ready_jobs[lv].pop_front();
        time_left = running.run;
        cpu_busy  = 1'b1;
        r.started = 1'b1;
      end
    end

    // The running job spends one quantum and may finish with it.
    if (cpu_busy) begin
      r.busy_res   = 1'b1;
      r.running_id = running.id;
      if (time_left <= QUANTUM) begin
        fin   = tick_now + 32'd1;
        fin_t = fin * QUANTUM;
        ta    = (fin_t > running.arr) ? fin_t - running.arr : 0;
        wt    = (ta > running.run) ? ta - running.run : 0;
        r.completed   = 1'b1;
        r.finish_tick = 13'(fin);
        r.turnaround  = 16'(ta);
        r.waiting     = 16'(wt);
        time_left     = 0;
        cpu_busy      = 1'b0;
      end else begin
        time_left -= QUANTUM;
      end
    end
    tick_now++;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      if (mismatches < 10) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
      mismatches++;
    end
  endtask

  // Results are checked before the same edge's item is predicted; the block
  // cannot answer an item in the cycle it takes it.
  always @(posedge clk) begin : watch
    result_t want;
    int      lv;
    if (rst) begin
      for (lv = 0; lv < NUM_LEVELS; lv++) begin
        ready_jobs[lv].delete();
      end
      cpu_busy  = 1'b0;
      running   = '0;
      time_left = 0;
      tick_now  = '0;
      outcome_fifo.delete();
    end else begin
      if (res_valid && !res_stall) begin
        if (outcome_fifo.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: result with none expected: %p", $time, res);
          end
          mismatches++;
        end else begin
          want = outcome_fifo.pop_front();
          check_field("dropped", want.dropped, res.dropped);
          check_field("busy_res", want.busy_res, res.busy_res);
          check_field("running_id", want.running_id, res.running_id);
          check_field("started", want.started, res.started);
          check_field("completed", want.completed, res.completed);
          check_field("finish_tick", want.finish_tick, res.finish_tick);
          check_field("turnaround", want.turnaround, res.turnaround);
          check_field("waiting", want.waiting, res.waiting);
        end
      end
      if (item_valid && !item_stall) begin
        outcome_fifo.push_back(schedule_outcome(item));
      end
    end
    pending <= outcome_fifo.size();
  end

endmodule

@@ sim/tb_hpf_nonpreemptive_scheduler.sv @@
`timescale 1ns / 100ps
// Testbench top for the priority scheduler: clock, reset, item stimulus and
// result stalls. Depends on hpf_pkg, the block and hpf_scheduler_checker.
module tb_hpf_nonpreemptive_scheduler;
  import hpf_pkg::*;

  localparam int QUEUE_DEPTH  = 256;
  localparam int NUM_LEVELS   = 4;
  localparam int PHASE_ITEMS  = 215;
  localparam int HOLD_CYCLES  = 300;
  localparam int STUCK_LIMIT  = 2000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    res_valid;
  logic    res_stall = 1'b0;
  result_t res;

  int mismatches;
  int pending;

  // Stimulus controls and bookkeeping.
  int   gap_pct = 0;
  int   stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   items_sent = 0;
  int   ticks_sent = 0;
  int   stuck_cycles = 0;

  hpf_nonpreemptive_scheduler #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .NUM_LEVELS (NUM_LEVELS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item      (item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  hpf_scheduler_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .NUM_LEVELS (NUM_LEVELS)
  ) u_checker (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item      (item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .mismatches(mismatches),
    .pending   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stalls, plus one long hold-off when requested.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      res_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: too many cycles in a row with no item moving on either side.
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (res_valid && !res_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  function automatic item_t job_item(input logic [2:0] prio, input logic [7:0] id,
                                     input logic [6:0] run, input logic [15:0] arr);
    item_t it;
    it.opcode       = OP_ARRIVE;
    it.job_id       = id;
    it.job_priority = prio;
    it.run_time     = run;
    it.arrival_time = arr;
    return it;
  endfunction

  // Tick items carry random content in the fields the block ignores.
  function automatic item_t tick_item();
    item_t it;
    it = job_item(3'($urandom), 8'($urandom), 7'($urandom), 16'($urandom));
    it.opcode = OP_TICK;
    return it;
  endfunction

  // Mostly short jobs that arrived shortly before the current tick.
  function automatic item_t random_job();
    logic [6:0]  run;
    logic [15:0] arr;
    run = ($urandom_range(9) < 8) ? 7'($urandom_range(1, 20)) : 7'($urandom_range(0, 127));
    arr = ($urandom_range(9) < 8) ? 16'(ticks_sent * 10 - $urandom_range(0, 60))
                                  : 16'($urandom);
    return job_item(3'($urandom_range(1, NUM_LEVELS)), 8'($urandom), run, arr);
  endfunction

  // Offers one item after a random gap and holds it until it is taken.
  task automatic offer(input item_t it);
    while ($urandom_range(99) < gap_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
    if (it.opcode == OP_TICK) ticks_sent++;
  endtask

  // Stops offering until every result owed has come back.
  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // One short arrive-then-run sequence, or now and then a fully random item.
  task automatic random_sequence();
    item_t it;
    if ($urandom_range(9) == 0) begin
      it = job_item(3'($urandom), 8'($urandom), 7'($urandom), 16'($urandom));
      it.opcode = 1'($urandom);
      offer(it);
    end else begin
      repeat ($urandom_range(0, 2)) offer(random_job());
      repeat ($urandom_range(1, 6)) offer(tick_item());
    end
  endtask

  task automatic random_phase();
    int stop_at;
    stop_at = items_sent + PHASE_ITEMS;
    while (items_sent < stop_at) random_sequence();
  endtask

  initial begin : stimulus
    int lv;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: idle tick, bad priorities, field extremes, no preemption.
    offer(tick_item());
    offer(job_item(3'd0, 8'd7, 7'd5, 16'd0));
    offer(job_item(3'd7, 8'd7, 7'd5, 16'd0));
    offer(job_item(3'd5, 8'd7, 7'd5, 16'd0));
    offer(job_item(3'd4, 8'hFF, 7'd127, 16'd0));
    // Zero run time, and an arrival later than the finish.
    offer(job_item(3'd1, 8'h00, 7'd0, 16'hFFFF));
    // Run time longer than the turnaround, so waiting bottoms out.
    offer(job_item(3'd2, 8'hA5, 7'd25, 16'd40));
    offer(job_item(3'd3, 8'h5A, 7'd1, 16'd0));
    repeat (6) offer(tick_item());
    // A higher level arrives while the long job runs; it must wait its turn.
    offer(job_item(3'd1, 8'h01, 7'd10, 16'd70));
    offer(job_item(3'd4, 8'h80, 7'd11, 16'd75));
    offer(tick_item());

    // Random phases with different idle patterns on each side.
    random_phase();
    wait_drained();

    gap_pct = 66;
    random_phase();
    wait_drained();

    // The receiver holds off at the start while the sender keeps going.
    gap_pct = 0;
    stall_pct <= 66;
    hold_req <= 1'b1;
    random_phase();

    // Both sides idle; one level gets flooded until arrivals are dropped.
    gap_pct = 34;
    stall_pct <= 34;
    lv = $urandom_range(1, NUM_LEVELS);
    repeat (QUEUE_DEPTH + 6) begin
      offer(job_item(3'(lv), 8'($urandom), 7'($urandom_range(0, 10)),
                     16'(ticks_sent * 10)));
    end
    random_phase();

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ hpf_nonpreemptive_scheduler.f @@
+incdir+src
src/hpf_pkg.sv
src/hpf_store.sv
src/hpf_result.sv
src/hpf_nonpreemptive_scheduler.sv
sim/hpf_scheduler_checker.sv
sim/tb_hpf_nonpreemptive_scheduler.sv
